[rtl/core/ffra_pkg.sv]
// shared types and constants for the first-fit resource map allocator
// no dependencies; used by the channel interfaces and the top level
package ffra_pkg;

   localparam int POOL_UNITS = 128;
   localparam int NODE_W     = $clog2(POOL_UNITS);
   localparam int LINK_W     = $clog2(POOL_UNITS + 1);

   localparam logic [LINK_W-1:0] LIST_END   = LINK_W'(POOL_UNITS);
   localparam logic [LINK_W-1:0] POOL_LEN   = LINK_W'(POOL_UNITS);
   localparam logic [LINK_W-1:0] SPARE_INIT = LINK_W'(POOL_UNITS - 1);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_ZERO_SIZE  = 3'd1,
      STS_NO_FIT     = 3'd2,
      STS_BAD_ADDR   = 3'd3,
      STS_FREE_LONG  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_SCAN,
      S_WRITE_A,
      S_WRITE_B,
      S_DONE
   } state_type;

   // one entry of the node memory
   typedef struct packed {
      logic              alloc;
      logic [LINK_W-1:0] link;
      logic [LINK_W-1:0] len;
      logic [NODE_W-1:0] start;
   } node_type;

   localparam node_type NODE_ZERO_INIT = '{alloc: 1'b0, link: LIST_END, len: POOL_LEN,
                                           start: '0};
   localparam node_type NODE_INIT      = '{alloc: 1'b0, link: LIST_END, len: '0,
                                           start: '0};

endpackage

[rtl/core/ffra_if.sv]
// valid/ready channel interfaces for request and response beats
// depends on ffra_pkg
interface ffra_req_if import ffra_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] block_size;
   logic [6:0] block_addr;

   modport source (output valid, action, block_size, block_addr, input ready);
   modport sink   (input valid, action, block_size, block_addr, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [6:0] start_addr;
   logic [7:0] free_blocks;
   logic [7:0] free_units;

   modport source (output valid, status, start_addr, free_blocks, free_units, input ready);
   modport sink   (input valid, status, start_addr, free_blocks, free_units, output ready);
endinterface

[rtl/core/first_fit_resource_map_allocator.sv]
// First-fit resource map allocator over a 128-unit pool. Each request beat gives one
// response beat. An allocate walks the free list one node per cycle, a free scans the
// node entries in index order one per cycle until it finds the block, both out of a
// single node memory with registered read data. An allocate walks at most 128 free
// blocks and a free scans at most 128 entries. Zero sizes and oversized allocations
// go straight to the done state. Node entries carry valid bits cleared at reset, so
// no clearing pass is needed. A finished response waits in its own register while the
// next request is accepted; the block only stalls in its done state while an earlier
// response beat is still unaccepted.
// depends on ffra_pkg and ffra_if
module first_fit_resource_map_allocator import ffra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ffra_req_if.sink   req_ch,
   ffra_rsp_if.source rsp_ch
);

   // node memory
   node_type          node_mem [POOL_UNITS];
   logic [POOL_UNITS-1:0] valid_ff;
   node_type          rd_raw_ff;
   logic              rd_valid_ff;
   logic [NODE_W-1:0] rd_addr_ff;
   logic [NODE_W-1:0] rd_addr;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   node_type          wr_data;
   node_type          node_q;

   // control and bookkeeping
   state_type         state_ff, state_in;
   logic [7:0]        size_ff, size_in;
   logic [6:0]        addr_ff, addr_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] spare_ff, spare_in;
   logic [7:0]        blocks_ff, blocks_in;
   logic [7:0]        units_ff, units_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   node_type          prev_word_ff, prev_word_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] idx_ff, idx_in;
   logic              ev_ff, ev_in;
   logic [NODE_W-1:0] wa_addr_ff, wa_addr_in, wb_addr_ff, wb_addr_in;
   node_type          wa_data_ff, wa_data_in, wb_data_ff, wb_data_in;
   status_type        sts_ff, sts_in;
   logic [6:0]        start_ff, start_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [6:0]        rsp_start_ff;
   logic [7:0]        rsp_blocks_ff, rsp_units_ff;

   // shared decisions
   logic              req_beat;
   logic              rsp_free;
   logic              fit, exact, spare_empty, hit, too_long;
   logic [LINK_W-1:0] next_link;
   logic [LINK_W-1:0] steps_inc;
   logic              scan_end;

   assign node_q = rd_valid_ff ? rd_raw_ff
                 : ((rd_addr_ff == '0) ? NODE_ZERO_INIT : NODE_INIT);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign fit         = node_q.len >= LINK_W'(size_ff);
   assign exact       = node_q.len == LINK_W'(size_ff);
   assign spare_empty = (spare_ff == '0);
   assign hit         = ev_ff && node_q.alloc && (node_q.start == addr_ff);
   assign too_long    = LINK_W'(size_ff) > node_q.len;
   assign next_link   = node_q.link;
   assign steps_inc   = steps_ff + LINK_W'(1);
   assign scan_end    = ev_ff && (rd_addr_ff == NODE_W'(POOL_UNITS - 1));

   // memory write, read with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_raw_ff <= node_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
      rd_addr_ff <= rd_addr;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_ch.block_size == '0) begin
                  state_in = S_DONE;
               end else if (req_ch.action == ACT_FREE) begin
                  state_in = S_FREE_SCAN;
               end else if (req_ch.block_size > units_ff || blocks_ff == '0
                            || head_ff[LINK_W-1]) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_ALLOC_SCAN;
               end
            end
         end
         S_ALLOC_SCAN: begin
            if (fit) begin
               state_in = (exact || !spare_empty) ? S_WRITE_A : S_DONE;
            end else if (next_link[LINK_W-1] || steps_inc == LINK_W'(POOL_UNITS)) begin
               state_in = S_DONE;
            end
         end
         S_FREE_SCAN: begin
            if (hit) begin
               if (too_long) begin
                  state_in = S_DONE;
               end else begin
                  state_in = (exact || !spare_empty) ? S_WRITE_A : S_DONE;
               end
            end else if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_WRITE_A: state_in = S_WRITE_B;
         S_WRITE_B: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      size_in      = size_ff;
      addr_in      = addr_ff;
      head_in      = head_ff;
      spare_in     = spare_ff;
      blocks_in    = blocks_ff;
      units_in     = units_ff;
      prev_in      = prev_ff;
      prev_word_in = prev_word_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      ev_in        = 1'b0;
      wa_addr_in   = wa_addr_ff;
      wa_data_in   = wa_data_ff;
      wb_addr_in   = wb_addr_ff;
      wb_data_in   = wb_data_ff;
      sts_in       = sts_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_addr      = rd_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = wa_addr_ff;
      wr_data      = wa_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               size_in  = req_ch.block_size;
               addr_in  = req_ch.block_addr;
               start_in = '0;
               prev_in  = LIST_END;
               steps_in = '0;
               idx_in   = '0;
               rd_addr  = head_ff[NODE_W-1:0];
               if (req_ch.block_size == '0) begin
                  sts_in = STS_ZERO_SIZE;
               end else begin
                  sts_in = STS_NO_FIT;
               end
            end
         end
         S_ALLOC_SCAN: begin
            if (fit) begin
               if (exact) begin
                  wb_addr_in       = rd_addr_ff;
                  wb_data_in       = node_q;
                  wb_data_in.link  = LIST_END;
                  wb_data_in.alloc = 1'b1;
                  if (prev_ff == LIST_END) begin
                     head_in    = next_link;
                     wa_addr_in = rd_addr_ff;
                     wa_data_in = wb_data_in;
                  end else begin
                     wa_addr_in      = prev_ff[NODE_W-1:0];
                     wa_data_in      = prev_word_ff;
                     wa_data_in.link = next_link;
                  end
                  blocks_in = blocks_ff - 8'd1;
                  units_in  = units_ff - size_ff;
                  sts_in    = STS_OK;
                  start_in  = node_q.start;
               end else if (!spare_empty) begin
                  wa_addr_in = spare_ff[NODE_W-1:0];
                  wa_data_in = '{alloc: 1'b1, link: LIST_END, len: LINK_W'(size_ff),
                                 start: node_q.start};
                  wb_addr_in = rd_addr_ff;
                  wb_data_in = node_q;
                  wb_data_in.start = node_q.start + NODE_W'(size_ff);
                  wb_data_in.len   = node_q.len - LINK_W'(size_ff);
                  spare_in  = spare_ff - LINK_W'(1);
                  units_in  = units_ff - size_ff;
                  sts_in    = STS_OK;
                  start_in  = node_q.start;
               end
            end else begin
               // step to the next free block
               prev_in      = LINK_W'(rd_addr_ff);
               prev_word_in = node_q;
               steps_in     = steps_inc;
               rd_addr      = next_link[NODE_W-1:0];
            end
         end
         S_FREE_SCAN: begin
            // issue one entry per cycle, check the previous one
            if (!idx_ff[LINK_W-1]) begin
               rd_addr = idx_ff[NODE_W-1:0];
               idx_in  = idx_ff + LINK_W'(1);
               ev_in   = 1'b1;
            end
            if (hit) begin
               ev_in = 1'b0;
               if (too_long) begin
                  sts_in = STS_FREE_LONG;
               end else if (exact) begin
                  wa_addr_in       = rd_addr_ff;
                  wa_data_in       = node_q;
                  wa_data_in.alloc = 1'b0;
                  wa_data_in.link  = head_ff;
                  wb_addr_in       = rd_addr_ff;
                  wb_data_in       = wa_data_in;
                  head_in   = LINK_W'(rd_addr_ff);
                  blocks_in = blocks_ff + 8'd1;
                  units_in  = units_ff + size_ff;
                  sts_in    = STS_OK;
               end else if (!spare_empty) begin
                  wa_addr_in = spare_ff[NODE_W-1:0];
                  wa_data_in = '{alloc: 1'b0, link: head_ff, len: LINK_W'(size_ff),
                                 start: addr_ff};
                  wb_addr_in = rd_addr_ff;
                  wb_data_in = node_q;
                  wb_data_in.start = node_q.start + NODE_W'(size_ff);
                  wb_data_in.len   = node_q.len - LINK_W'(size_ff);
                  head_in   = spare_ff;
                  spare_in  = spare_ff - LINK_W'(1);
                  blocks_in = blocks_ff + 8'd1;
                  units_in  = units_ff + size_ff;
                  sts_in    = STS_OK;
               end
            end else if (scan_end) begin
               ev_in  = 1'b0;
               sts_in = STS_BAD_ADDR;
            end
         end
         S_WRITE_A: begin
            wr_en   = 1'b1;
            wr_addr = wa_addr_ff;
            wr_data = wa_data_ff;
         end
         S_WRITE_B: begin
            wr_en   = 1'b1;
            wr_addr = wb_addr_ff;
            wr_data = wb_data_ff;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         spare_ff     <= SPARE_INIT;
         blocks_ff    <= 8'd1;
         units_ff     <= 8'(POOL_UNITS);
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         spare_ff     <= spare_in;
         blocks_ff    <= blocks_in;
         units_ff     <= units_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      prev_ff      <= prev_in;
      prev_word_ff <= prev_word_in;
      steps_ff     <= steps_in;
      idx_ff       <= idx_in;
      wa_addr_ff   <= wa_addr_in;
      wa_data_ff   <= wa_data_in;
      wb_addr_ff   <= wb_addr_in;
      wb_data_ff   <= wb_data_in;
      sts_ff       <= sts_in;
      start_ff     <= start_in;
   end

   // response beat
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff <= sts_ff;
         rsp_start_ff  <= start_ff;
         rsp_blocks_ff <= blocks_ff;
         rsp_units_ff  <= units_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.start_addr  = rsp_start_ff;
   assign rsp_ch.free_blocks = rsp_blocks_ff;
   assign rsp_ch.free_units  = rsp_units_ff;

endmodule

[test/ffra_checker.sv]
// watches the request and response channels, predicts each response beat and compares
// depends on ffra_pkg
module ffra_checker import ffra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_block_size,
   input  logic [6:0] req_block_addr,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_status,
   input  logic [6:0] rsp_start_addr,
   input  logic [7:0] rsp_free_blocks,
   input  logic [7:0] rsp_free_units,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      status_type status;
      logic [6:0] start_addr;
      logic [7:0] free_blocks;
      logic [7:0] free_units;
   } answer_type;

   // shadow resource map
   int unsigned seg_start [POOL_UNITS];
   int unsigned seg_len   [POOL_UNITS];
   int unsigned seg_link  [POOL_UNITS];
   bit          seg_used  [POOL_UNITS];
   int unsigned spare_stack [POOL_UNITS];
   int unsigned head, spares, nblocks, nunits;

   answer_type expected_answers [$];

   function automatic void map_reset();
      for (int i = 0; i < POOL_UNITS; i++) begin
         seg_start[i] = 0; seg_len[i] = 0; seg_used[i] = 0;
         seg_link[i] = POOL_UNITS; spare_stack[i] = 0;
      end
      seg_len[0] = POOL_UNITS;
      for (int i = 1; i < POOL_UNITS; i++) spare_stack[i-1] = i;
      head = 0; spares = POOL_UNITS - 1; nblocks = 1; nunits = POOL_UNITS;
   endfunction

   function automatic bit pop_spare(output int unsigned idx);
      if (spares == 0) return 0;
      idx = spare_stack[spares-1];
      spares--;
      return 1;
   endfunction

   function automatic status_type carve(int unsigned size, output int unsigned start);
      int unsigned prev, cur, steps, n;
      prev = POOL_UNITS; cur = head; steps = 0; start = 0;
      if (size == 0) return STS_ZERO_SIZE;
      if (size > nunits || nblocks == 0) return STS_NO_FIT;
      while (cur < POOL_UNITS && steps < POOL_UNITS) begin
         if (seg_len[cur] >= size) begin
            if (seg_len[cur] == size) begin
               if (prev == POOL_UNITS) head = seg_link[cur];
               else seg_link[prev] = seg_link[cur];
               seg_link[cur] = POOL_UNITS;
               seg_used[cur] = 1;
               nblocks--;
               start = seg_start[cur];
            end else begin
               if (!pop_spare(n)) return STS_NO_FIT;
               seg_start[n] = seg_start[cur]; seg_len[n] = size;
               seg_link[n] = POOL_UNITS; seg_used[n] = 1;
               seg_start[cur] += size; seg_len[cur] -= size;
               start = seg_start[n];
            end
            nunits -= size;
            return STS_OK;
         end
         prev = cur; cur = seg_link[cur]; steps++;
      end
      return STS_NO_FIT;
   endfunction

   function automatic status_type release_units(int unsigned size, int unsigned addr);
      int unsigned i, n;
      if (size == 0) return STS_ZERO_SIZE;
      for (i = 0; i < POOL_UNITS; i++)
         if (seg_used[i] && seg_start[i] == addr) break;
      if (i >= POOL_UNITS) return STS_BAD_ADDR;
      if (size > seg_len[i]) return STS_FREE_LONG;
      if (size == seg_len[i]) begin
         seg_used[i] = 0; n = i;
      end else begin
         if (!pop_spare(n)) return STS_NO_FIT;
         seg_start[n] = addr; seg_len[n] = size; seg_used[n] = 0;
         seg_start[i] += size; seg_len[i] -= size;
      end
      seg_link[n] = head; head = n;
      nblocks++; nunits += size;
      return STS_OK;
   endfunction

   // predict on request beats, compare on response beats
   always @(posedge clock) begin
      answer_type want, got;
      int unsigned st;
      if (reset) begin
         map_reset();
         expected_answers.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            st = 0;
            if (req_action == ACT_ALLOC)
               want.status = carve(int'(req_block_size), st);
            else
               want.status = release_units(int'(req_block_size), int'(req_block_addr));
            if (want.status != STS_OK || req_action != ACT_ALLOC) st = 0;
            want.start_addr  = st[6:0];
            want.free_blocks = nblocks[7:0];
            want.free_units  = nunits[7:0];
            expected_answers.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{status_type'(rsp_status), rsp_start_addr, rsp_free_blocks,
                    rsp_free_units};
            if (expected_answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected response beat %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_answers.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("response mismatch: expected %p got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_answers.size();
   end

endmodule

[test/tb_first_fit_resource_map_allocator.sv]
// stimulus and verdict for the first-fit resource map allocator
// depends on ffra_pkg, ffra_if, the allocator and ffra_checker
module tb_first_fit_resource_map_allocator;
   import ffra_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   fail_count, pending_count;
   logic [6:0] live_addr [$];

   ffra_req_if req_ch ();
   ffra_rsp_if rsp_ch ();

   first_fit_resource_map_allocator u_top (
      .clock (clock), .reset (reset), .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source)
   );

   ffra_checker u_checker (
      .clock (clock), .reset (reset),
      .req_valid (req_ch.valid), .req_ready (req_ch.ready), .req_action (req_ch.action),
      .req_block_size (req_ch.block_size), .req_block_addr (req_ch.block_addr),
      .rsp_valid (rsp_ch.valid), .rsp_ready (rsp_ch.ready), .rsp_status (rsp_ch.status),
      .rsp_start_addr (rsp_ch.start_addr), .rsp_free_blocks (rsp_ch.free_blocks),
      .rsp_free_units (rsp_ch.free_units),
      .fail_count (fail_count), .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // remember start addresses of successful responses (up to 64) for later frees
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STS_OK &&
          rsp_ch.start_addr != 0 || (!reset && rsp_ch.valid && rsp_ch.ready &&
          rsp_ch.status == STS_OK && rsp_ch.free_units != POOL_UNITS))
         if (live_addr.size() < 64) live_addr.push_back(rsp_ch.start_addr);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // random stalls on the response side, with stretches of none
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if ((cycles / 3000) % 3 == 2) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= (gap_len() == 0);
      end
   end

   task automatic send_beat(input logic act, input logic [7:0] size, input logic [6:0] addr);
      int g;
      g = ((cycles / 3000) % 3 == 2) ? 0 : gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.block_size <= size;
      req_ch.block_addr <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic random_beat();
      int r;
      logic [6:0] a;
      r = $urandom_range(0, 99);
      if (r < 45)
         send_beat(ACT_ALLOC, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                   : 8'($urandom_range(1, 12)), 7'($urandom));
      else if (r < 85 && live_addr.size() > 0) begin
         a = live_addr[$urandom_range(0, live_addr.size() - 1)];
         send_beat(ACT_FREE, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                   : 8'($urandom_range(1, 6)), a);
      end else
         send_beat(1'($urandom), 8'($urandom), 7'($urandom));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_ALLOC;
      req_ch.block_size = '0;
      req_ch.block_addr = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: edges, zero sizes, bad addresses, over-long frees, full pool
      send_beat(ACT_ALLOC, 8'd0, 7'd0);
      send_beat(ACT_FREE, 8'd0, 7'd0);
      send_beat(ACT_FREE, 8'd1, 7'd0);
      send_beat(ACT_ALLOC, 8'd255, 7'd127);
      send_beat(ACT_ALLOC, 8'd129, 7'd0);
      send_beat(ACT_ALLOC, 8'd128, 7'd0);
      send_beat(ACT_ALLOC, 8'd1, 7'd0);
      send_beat(ACT_FREE, 8'd129, 7'd0);
      send_beat(ACT_FREE, 8'd127, 7'd0);
      send_beat(ACT_FREE, 8'd1, 7'd127);
      send_beat(ACT_FREE, 8'd1, 7'd0);
      send_beat(ACT_ALLOC, 8'd1, 7'd0);
      send_beat(ACT_ALLOC, 8'd126, 7'd0);
      send_beat(ACT_ALLOC, 8'd1, 7'd0);
      send_beat(ACT_FREE, 8'd126, 7'd1);
      send_beat(ACT_FREE, 8'd1, 7'd127);
      send_beat(ACT_FREE, 8'd1, 7'd0);
      send_beat(ACT_ALLOC, 8'd64, 7'd0);
      send_beat(ACT_ALLOC, 8'd2, 7'd0);
      send_beat(ACT_FREE, 8'd2, 7'h7f);
      repeat (930) random_beat();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ffra_pkg.sv
rtl/core/ffra_if.sv
rtl/core/first_fit_resource_map_allocator.sv
test/ffra_checker.sv
test/tb_first_fit_resource_map_allocator.sv
